// ===== rtl/mat3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// mat3inv_pkg
// Shared widths, types and an index table for the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package mat3inv_pkg;

  localparam int unsigned NumEl   = 9;   // elements of one matrix
  localparam int unsigned ElemW   = 16;  // Q8.8 element
  localparam int unsigned ProdW   = 32;  // element times element
  localparam int unsigned AdjW    = 33;  // difference of two products
  localparam int unsigned DetPW   = 49;  // element times cofactor
  localparam int unsigned DetW    = 50;  // sum of three of those
  localparam int unsigned MagW    = 48;  // magnitude of numerator and determinant
  localparam int unsigned DivBits = 18;  // quotient bits produced by the divider
  localparam int unsigned CmpW    = MagW + DivBits;
  localparam int unsigned DetOutW = 32;

  // Cofactor e is m[AdjIdx[e][0]] * m[AdjIdx[e][1]] - m[AdjIdx[e][2]] * m[AdjIdx[e][3]],
  // with m flattened row by row. The table already holds the adjugate order.
  localparam int unsigned AdjIdx [NumEl][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // Information that travels beside the divider remainders.
  typedef struct packed {
    logic [MagW-1:0]    dmag;      // |determinant|, Q.24
    logic [NumEl-1:0]   qneg;      // quotient sign per element
    logic [NumEl-1:0]   big;       // quotient magnitude at least 2^DivBits
    logic [DetOutW-1:0] det;       // saturated Q16.16 determinant
    logic               det_clip;  // determinant saturated
    logic               singular;  // exact determinant is zero
  } side_t;

endpackage

// ===== rtl/matrix3x3_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Throughput: one matrix per cycle while the output is not stalled; the nine
// restoring divider lanes retire one quotient bit per stage, which sets the
// pipeline depth.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit
  import mat3inv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] a00_i,
  input  logic signed [15:0] a01_i,
  input  logic signed [15:0] a02_i,
  input  logic signed [15:0] a10_i,
  input  logic signed [15:0] a11_i,
  input  logic signed [15:0] a12_i,
  input  logic signed [15:0] a20_i,
  input  logic signed [15:0] a21_i,
  input  logic signed [15:0] a22_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] b00_o,
  output logic signed [15:0] b01_o,
  output logic signed [15:0] b02_o,
  output logic signed [15:0] b10_o,
  output logic signed [15:0] b11_o,
  output logic signed [15:0] b12_o,
  output logic signed [15:0] b20_o,
  output logic signed [15:0] b21_o,
  output logic signed [15:0] b22_o,
  output logic signed [31:0] determinant_o,
  output logic               singular_o,
  output logic               clipped_o
);

  // Stage map:
  //   1      eighteen element products
  //   2      nine cofactors
  //   3      first-row expansion products
  //   4      determinant sum, numerator magnitudes
  //   5      determinant magnitude and sign
  //   6      Q16.16 determinant, divider overflow check
  //   7..24  one quotient bit per stage, MSB first
  //   25     sign, saturation and output register
  localparam int unsigned NStg = 7 + DivBits;

  logic adv;
  logic [NStg-1:0] vld_q;

  // The pipeline moves as one unit unless a finished result is held back.
  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  logic signed [ElemW-1:0] m [NumEl];
  assign m[0] = a00_i;
  assign m[1] = a01_i;
  assign m[2] = a02_i;
  assign m[3] = a10_i;
  assign m[4] = a11_i;
  assign m[5] = a12_i;
  assign m[6] = a20_i;
  assign m[7] = a21_i;
  assign m[8] = a22_i;

  // Stage 1: the two products of every 2x2 minor, plus the first row.
  logic signed [ProdW-1:0] pa_q [NumEl];
  logic signed [ProdW-1:0] pb_q [NumEl];
  logic signed [ElemW-1:0] r0_s1_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < NumEl; e++) begin
        pa_q[e] <= m[AdjIdx[e][0]] * m[AdjIdx[e][1]];
        pb_q[e] <= m[AdjIdx[e][2]] * m[AdjIdx[e][3]];
      end
      for (int c = 0; c < 3; c++) begin
        r0_s1_q[c] <= m[c];
      end
    end
  end

  // Stage 2: exact cofactors in adjugate order.
  logic signed [AdjW-1:0]  adj_s2_q [NumEl];
  logic signed [ElemW-1:0] r0_s2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < NumEl; e++) begin
        adj_s2_q[e] <= AdjW'(pa_q[e]) - AdjW'(pb_q[e]);
      end
      r0_s2_q <= r0_s1_q;
    end
  end

  // Stage 3: expansion along the first row uses adjugate entries 0, 3 and 6.
  logic signed [DetPW-1:0] dp_q [3];
  logic signed [AdjW-1:0]  adj_s3_q [NumEl];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        dp_q[c] <= DetPW'(r0_s2_q[c]) * DetPW'(adj_s2_q[3*c]);
      end
      adj_s3_q <= adj_s2_q;
    end
  end

  // Stage 4: determinant and the numerators |C| * 2^16.
  logic signed [DetW-1:0] d_s4_q;
  logic [MagW-1:0]        nmag_s4_q [NumEl];
  logic [NumEl-1:0]       nneg_s4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_s4_q <= DetW'(dp_q[0]) + DetW'(dp_q[1]) + DetW'(dp_q[2]);
      for (int e = 0; e < NumEl; e++) begin
        logic [AdjW-1:0] aabs;
        aabs = adj_s3_q[e][AdjW-1] ? AdjW'(-adj_s3_q[e]) : AdjW'(adj_s3_q[e]);
        nmag_s4_q[e] <= {aabs[31:0], 16'h0000};
        nneg_s4_q[e] <= adj_s3_q[e][AdjW-1];
      end
    end
  end

  // Stage 5: determinant magnitude and sign.
  logic [MagW-1:0]  dmag_s5_q;
  logic             dneg_s5_q;
  logic             sing_s5_q;
  logic [MagW-1:0]  nmag_s5_q [NumEl];
  logic [NumEl-1:0] nneg_s5_q;
  logic [DetW-1:0]  dabs;

  assign dabs = d_s4_q[DetW-1] ? DetW'(-d_s4_q) : DetW'(d_s4_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_s5_q <= dabs[MagW-1:0];
      dneg_s5_q <= d_s4_q[DetW-1];
      sing_s5_q <= (d_s4_q == '0);
      nmag_s5_q <= nmag_s4_q;
      nneg_s5_q <= nneg_s4_q;
    end
  end

  // Stage 6: Q16.16 determinant truncated toward zero and saturated, and the
  // check whether a quotient needs more bits than the divider produces.
  side_t           side_q [DivBits+1];
  logic [MagW-1:0] rem_q  [DivBits+1][NumEl];
  logic [DivBits-1:0] quo_q [DivBits+1][NumEl];

  logic [MagW-9:0] dm8;
  side_t           side_d;
  logic [CmpW-1:0] dlim;

  assign dm8  = dmag_s5_q[MagW-1:8];
  assign dlim = {dmag_s5_q, {DivBits{1'b0}}};

  always_comb begin
    side_d          = '0;
    side_d.dmag     = dmag_s5_q;
    side_d.singular = sing_s5_q;
    for (int e = 0; e < NumEl; e++) begin
      side_d.qneg[e] = nneg_s5_q[e] ^ dneg_s5_q;
      side_d.big[e]  = {{DivBits{1'b0}}, nmag_s5_q[e]} >= dlim;
    end
    if (dneg_s5_q) begin
      if (dm8 > (MagW-8)'(64'h8000_0000)) begin
        side_d.det      = 32'h8000_0000;
        side_d.det_clip = 1'b1;
      end else begin
        side_d.det = DetOutW'(-dm8);
      end
    end else begin
      if (dm8 > (MagW-8)'(64'h7FFF_FFFF)) begin
        side_d.det      = 32'h7FFF_FFFF;
        side_d.det_clip = 1'b1;
      end else begin
        side_d.det = DetOutW'(dm8);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int e = 0; e < NumEl; e++) begin
        rem_q[0][e] <= nmag_s5_q[e];
        quo_q[0][e] <= '0;
      end
    end
  end

  // Stages 7..24: restoring division, quotient bit DivBits-j at stage j.
  for (genvar j = 1; j <= DivBits; j++) begin : g_div
    localparam int unsigned K = DivBits - j;
    logic [CmpW-1:0] dsh;
    assign dsh = {{DivBits{1'b0}}, side_q[j-1].dmag} << K;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[j] <= side_q[j-1];
        for (int e = 0; e < NumEl; e++) begin
          if ({{DivBits{1'b0}}, rem_q[j-1][e]} >= dsh) begin
            rem_q[j][e]    <= rem_q[j-1][e] - dsh[MagW-1:0];
            quo_q[j][e]    <= quo_q[j-1][e] | (DivBits'(1) << K);
          end else begin
            rem_q[j][e]    <= rem_q[j-1][e];
            quo_q[j][e]    <= quo_q[j-1][e];
          end
        end
      end
    end
  end

  // Stage 25: apply the sign, saturate to Q8.8, and zero a singular result.
  side_t sf;
  logic signed [ElemW-1:0] b_d [NumEl];
  logic [NumEl-1:0]        bclip;
  logic signed [ElemW-1:0] b_q [NumEl];
  logic signed [31:0]      det_q;
  logic                    sing_q;
  logic                    clip_q;

  assign sf = side_q[DivBits];

  always_comb begin
    for (int e = 0; e < NumEl; e++) begin
      logic [DivBits-1:0] q;
      q        = quo_q[DivBits][e];
      bclip[e] = 1'b0;
      if (sf.qneg[e]) begin
        if (sf.big[e] || q > DivBits'(32768)) begin
          b_d[e]   = 16'sh8000;
          bclip[e] = 1'b1;
        end else begin
          b_d[e] = ElemW'(-q);
        end
      end else begin
        if (sf.big[e] || q > DivBits'(32767)) begin
          b_d[e]   = 16'sh7FFF;
          bclip[e] = 1'b1;
        end else begin
          b_d[e] = ElemW'(q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < NumEl; e++) begin
        b_q[e] <= sf.singular ? '0 : b_d[e];
      end
      det_q  <= sf.singular ? '0 : sf.det;
      sing_q <= sf.singular;
      clip_q <= !sf.singular && ((|bclip) || sf.det_clip);
    end
  end

  assign b00_o         = b_q[0];
  assign b01_o         = b_q[1];
  assign b02_o         = b_q[2];
  assign b10_o         = b_q[3];
  assign b11_o         = b_q[4];
  assign b12_o         = b_q[5];
  assign b20_o         = b_q[6];
  assign b21_o         = b_q[7];
  assign b22_o         = b_q[8];
  assign determinant_o = det_q;
  assign singular_o    = sing_q;
  assign clipped_o     = clip_q;

`ifndef SYNTHESIS
  // A singular matrix always reports a zero determinant and no saturation.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> determinant_o == '0 && !clipped_o && b11_o == '0)
    else $error("singular result carries nonzero data");

  // A held result freezes every stage, so the valid pattern cannot move.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vld_q))
    else $error("pipeline moved while output was stalled");

  // After the last quotient bit the remainder is below the divisor, unless the
  // quotient was too large for the divider and saturates anyway.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NStg-2] && !sf.singular |-> (sf.big[0] || rem_q[DivBits][0] < sf.dmag)
      && (sf.big[8] || rem_q[DivBits][8] < sf.dmag))
    else $error("divider remainder out of range");
`endif

endmodule

// ===== tb/sv/matrix3x3_inverse_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit_tb
// Self-checking bench for the 3x3 fixed-point matrix inverse. A short table of
// directed matrices is followed by random ones; every accepted result is
// compared field by field with a software prediction held in a queue.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit_tb;
  import mat3inv_pkg::*;

  localparam int unsigned NumDirected = 14;
  localparam int unsigned NumRandom   = 1600;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 40;

  // One result transaction as the block presents it.
  typedef struct {
    logic signed [15:0] b [NumEl];
    logic signed [31:0] det;
    logic               sing;
    logic               clip;
  } inverse_t;

  // One directed row: the matrix, and a typed-in result where it is obvious.
  typedef struct {
    logic signed [15:0] a [NumEl];
    bit                 typed;
    inverse_t           res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic signed [15:0] a_q [NumEl];
  logic signed [15:0] b_w [NumEl];
  logic signed [31:0] determinant_o;
  logic singular_o, clipped_o;

  inverse_t  expected_q [$];
  stim_row_t rows [NumDirected];
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;

  always #4 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < NumEl; i++) begin
      a_q[i] = '0;
    end
  end

  matrix3x3_inverse_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .a00_i        (a_q[0]),
    .a01_i        (a_q[1]),
    .a02_i        (a_q[2]),
    .a10_i        (a_q[3]),
    .a11_i        (a_q[4]),
    .a12_i        (a_q[5]),
    .a20_i        (a_q[6]),
    .a21_i        (a_q[7]),
    .a22_i        (a_q[8]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .b00_o        (b_w[0]),
    .b01_o        (b_w[1]),
    .b02_o        (b_w[2]),
    .b10_o        (b_w[3]),
    .b11_o        (b_w[4]),
    .b12_o        (b_w[5]),
    .b20_o        (b_w[6]),
    .b21_o        (b_w[7]),
    .b22_o        (b_w[8]),
    .determinant_o(determinant_o),
    .singular_o   (singular_o),
    .clipped_o    (clipped_o)
  );

  // Computes the inverse by adjugate: exact cofactors scaled by 2^16, exact
  // determinant scaled by 2^24, then truncating divisions and saturation.
  function automatic inverse_t invert_matrix(input logic signed [15:0] a [NumEl]);
    longint m [NumEl];
    longint cof [NumEl];
    longint d, q;
    inverse_t r;
    for (int i = 0; i < NumEl; i++) begin
      m[i] = a[i];
    end
    cof[0] = m[4] * m[8] - m[5] * m[7];
    cof[1] = m[2] * m[7] - m[1] * m[8];
    cof[2] = m[1] * m[5] - m[2] * m[4];
    cof[3] = m[5] * m[6] - m[3] * m[8];
    cof[4] = m[0] * m[8] - m[2] * m[6];
    cof[5] = m[2] * m[3] - m[0] * m[5];
    cof[6] = m[3] * m[7] - m[4] * m[6];
    cof[7] = m[1] * m[6] - m[0] * m[7];
    cof[8] = m[0] * m[4] - m[1] * m[3];
    d = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
    r.clip = 1'b0;
    r.sing = (d == 0);
    r.det  = '0;
    for (int i = 0; i < NumEl; i++) begin
      r.b[i] = '0;
    end
    if (d != 0) begin
      // SystemVerilog integer division truncates toward zero, as required.
      for (int i = 0; i < NumEl; i++) begin
        q = (cof[i] * 65536) / d;
        if (q > 32767) begin
          q = 32767;
          r.clip = 1'b1;
        end else if (q < -32768) begin
          q = -32768;
          r.clip = 1'b1;
        end
        r.b[i] = q[15:0];
      end
      q = d / 256;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647;
        r.clip = 1'b1;
      end else if (q < -64'sd2147483648) begin
        q = -64'sd2147483648;
        r.clip = 1'b1;
      end
      r.det = q[31:0];
    end
    return r;
  endfunction

  function automatic inverse_t zero_result(input bit sing);
    inverse_t r;
    for (int i = 0; i < NumEl; i++) begin
      r.b[i] = '0;
    end
    r.det  = '0;
    r.sing = sing;
    r.clip = 1'b0;
    return r;
  endfunction

  // Builds a directed row from a diagonal and off-diagonal fill value.
  function automatic stim_row_t make_row(input logic signed [15:0] dg,
                                         input logic signed [15:0] off);
    stim_row_t s;
    for (int i = 0; i < NumEl; i++) begin
      s.a[i] = (i % 4 == 0) ? dg : off;
    end
    s.typed = 1'b0;
    s.res = zero_result(1'b0);
    return s;
  endfunction

  // Random matrix: mostly well-conditioned near-identity, some full range,
  // some rank-deficient and some tiny elements with tiny determinants.
  function automatic void random_matrix(output logic signed [15:0] a [NumEl]);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < NumEl; i++) begin
      case (kind)
        0, 1: a[i] = 16'($urandom());
        2: a[i] = $signed(16'($urandom_range(0, 8))) - 16'sd4;
        default: begin
          a[i] = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
          if (i % 4 == 0) begin
            a[i] = a[i] + ($urandom_range(0, 1) ? 16'sd1024 : -16'sd1024);
          end
        end
      endcase
    end
    if (kind == 3) begin
      // Row 2 copies row 0, so the exact determinant is zero.
      for (int c = 0; c < 3; c++) begin
        a[6 + c] = a[c];
      end
    end
  endfunction

  task automatic send_matrix(input logic signed [15:0] a [NumEl]);
    // Random gaps between bursts; bursts end with probability one in eight.
    if ($urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < NumEl; i++) begin
      a_q[i] <= a[i];
    end
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(invert_matrix(a));
  endtask

  // Receiver stall pattern: long open stretches and bursts of stalling.
  initial begin
    int unsigned mode;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk_i);
        out_stall_i <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
      end
    end
  end

  // Result checker: each accepted result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    inverse_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        for (int i = 0; i < NumEl; i++) begin
          if (b_w[i] !== exp_r.b[i]) begin
            $error("b%0d%0d: expected %0d, got %0d", i / 3, i % 3, exp_r.b[i], b_w[i]);
            fail_count++;
          end
        end
        if (determinant_o !== exp_r.det) begin
          $error("determinant: expected %0d, got %0d", exp_r.det, determinant_o);
          fail_count++;
        end
        if (singular_o !== exp_r.sing) begin
          $error("singular: expected %0b, got %0b", exp_r.sing, singular_o);
          fail_count++;
        end
        if (clipped_o !== exp_r.clip) begin
          $error("clipped: expected %0b, got %0b", exp_r.clip, clipped_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni
        || (stim_done && expected_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] mat [NumEl];
    inverse_t pred;

    // Directed table. Typed rows hold results that follow directly.
    rows[0] = make_row(16'sd0, 16'sd0);        // all zero: singular
    rows[0].typed = 1'b1;
    rows[0].res = zero_result(1'b1);
    rows[1] = make_row(16'sd256, 16'sd0);      // identity
    rows[1].typed = 1'b1;
    rows[1].res = zero_result(1'b0);
    for (int i = 0; i < NumEl; i += 4) begin
      rows[1].res.b[i] = 16'sd256;
    end
    rows[1].res.det = 32'sd65536;
    rows[2] = make_row(16'sd32767, 16'sd32767); // all max: singular
    rows[2].typed = 1'b1;
    rows[2].res = zero_result(1'b1);
    rows[3] = make_row(-16'sd32768, 16'sd0);   // most negative diagonal
    rows[4] = make_row(16'sd32767, 16'sd0);    // largest diagonal: determinant clips
    rows[5] = make_row(16'sd1, 16'sd0);        // tiny determinant truncates to zero
    rows[6] = make_row(-16'sd1, 16'sd0);
    rows[7] = make_row(16'sd512, 16'sd256);
    rows[8] = make_row(-16'sd32768, 16'sd32767);
    rows[9] = make_row(16'sd32767, -16'sd32768);
    rows[10] = make_row(16'sd256, -16'sd1);
    rows[11] = make_row(16'sd2, 16'sd1);
    rows[12] = make_row(-16'sd256, 16'sd128);
    rows[13] = make_row(16'sd0, 16'sd256);     // permutation-like, negative cofactors

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      pred = invert_matrix(rows[r].a);
      if (rows[r].typed && (pred.sing !== rows[r].res.sing || pred.det !== rows[r].res.det
          || pred.b[0] !== rows[r].res.b[0])) begin
        $error("directed row %0d: typed result disagrees with prediction", r);
        fail_count++;
      end
      send_matrix(rows[r].a);
      if (rows[r].typed) begin
        void'(expected_q.pop_back());
        expected_q.push_back(rows[r].res);
      end
    end

    for (int n = 0; n < NumRandom; n++) begin
      random_matrix(mat);
      send_matrix(mat);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
